// File: rtl/core/cdt_pkg.sv
// Package for the countdown timer controller: payload types, codes,
// register reset values and arithmetic constants. No dependencies.
package cdt_pkg;

  localparam int unsigned CountW = 13;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned DebW   = 14;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] MAX_SECONDS = 13'd5999;

  localparam logic [15:0]     RESET_MS_PER_SECOND = 16'd1000;
  localparam logic [DebW-1:0] RESET_DEBOUNCE_MS   = 14'd100;
  localparam logic [15:0]     RESET_SHORT_BEEP_MS = 16'd100;
  localparam logic [15:0]     RESET_LONG_BEEP_MS  = 16'd1000;
  localparam logic [15:0]     RESET_BEEP_LEFT     = 16'd100;

  localparam logic [CountW-1:0] WARN_SECONDS = 13'd5;

  // Reciprocal multipliers for the mm:ss split.
  localparam logic [14:0] DIV60_MUL   = 15'd17477;
  localparam int unsigned DIV60_SHIFT = 20;
  localparam logic [7:0]  DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam logic [CfgIdxW-1:0] REG_MS_PER_SECOND = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SHORT_BEEP_MS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG_BEEP_MS  = 2'd3;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_PLAY  = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_TURN  = 3'd3,
    MODE_PRESS = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       turn_up;
    logic       long_end_beep;
    logic       warn_enable;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] seconds_left;
    logic              beeper_on;
    logic              is_armed;
    logic              expired;
    logic              report_time;
    logic              ignored;
  } res_t;

  typedef struct packed {
    res_t       res;
    logic [3:0] minutes_tens;
    logic [3:0] minutes_ones;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
  } disp_t;

  function automatic logic [5:0] step_for(logic [CountW-1:0] v);
    logic [5:0] s;
    if (v < 13'd30) begin
      s = 6'd5;
    end else if (v < 13'd120) begin
      s = 6'd10;
    end else if (v < 13'd300) begin
      s = 6'd30;
    end else begin
      s = 6'd60;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/cdt_if.sv
// Valid/ready channel interfaces for the countdown timer controller.
// Depends on nothing but plain logic types.
interface cdt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       turn_up;
  logic       long_end_beep;
  logic       warn_enable;

  modport source (output valid, mode, turn_up, long_end_beep, warn_enable, input ready);
  modport sink   (input valid, mode, turn_up, long_end_beep, warn_enable, output ready);
endinterface

interface cdt_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] seconds_left;
  logic [3:0]  minutes_tens;
  logic [3:0]  minutes_ones;
  logic [2:0]  seconds_tens;
  logic [3:0]  seconds_ones;
  logic        beeper_on;
  logic        is_armed;
  logic        expired;
  logic        report_time;
  logic        ignored;

  modport source (output valid, seconds_left, minutes_tens, minutes_ones, seconds_tens,
                  seconds_ones, beeper_on, is_armed, expired, report_time, ignored,
                  input ready);
  modport sink   (input valid, seconds_left, minutes_tens, minutes_ones, seconds_tens,
                  seconds_ones, beeper_on, is_armed, expired, report_time, ignored,
                  output ready);
endinterface

// File: rtl/core/cdt_core.sv
// Input register, configuration registers and timer state update.
// Depends on cdt_pkg.
module cdt_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cdt_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cdt_pkg::item_t                in_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output cdt_pkg::res_t                 res_o
);

  logic [15:0]                   ms_q;
  logic [cdt_pkg::DebW-1:0]      deb_q;
  logic [15:0]                   short_q;
  logic [15:0]                   long_q;

  logic                          s0_v_q;
  cdt_pkg::item_t                s0_q;
  logic                          s1_v_q;
  cdt_pkg::res_t                 s1_q;
  cdt_pkg::res_t                 res_d;

  logic [15:0]                   tick_q, tick_d;
  logic [15:0]                   cool_q, cool_d;
  logic [15:0]                   beep_q, beep_d;
  logic [cdt_pkg::CountW-1:0]    preset_q, preset_d;
  logic [cdt_pkg::CountW-1:0]    count_q, count_d;
  logic                          run_q, run_d;

  logic                          s1_rdy;
  logic                          adv;
  logic [15:0]                   tick_inc;
  logic                          sec;
  logic [cdt_pkg::CountW:0]      up_sum;
  logic [cdt_pkg::CountW-1:0]    count_m1;
  logic [15:0]                   deb_x1;
  logic [15:0]                   deb_x2;
  logic                          expired, report, ignored;

  assign s1_rdy      = !s1_v_q || res_ready_i;
  assign adv         = s0_v_q && s1_rdy;
  assign in_ready_o  = !s0_v_q || s1_rdy;
  assign res_valid_o = s1_v_q;
  assign res_o       = s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q    <= cdt_pkg::RESET_MS_PER_SECOND;
      deb_q   <= cdt_pkg::RESET_DEBOUNCE_MS;
      short_q <= cdt_pkg::RESET_SHORT_BEEP_MS;
      long_q  <= cdt_pkg::RESET_LONG_BEEP_MS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cdt_pkg::REG_MS_PER_SECOND: ms_q    <= cfg_data_i;
        cdt_pkg::REG_DEBOUNCE_MS:   deb_q   <= cfg_data_i[cdt_pkg::DebW-1:0];
        cdt_pkg::REG_SHORT_BEEP_MS: short_q <= cfg_data_i;
        cdt_pkg::REG_LONG_BEEP_MS:  long_q  <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      tick_q   <= '0;
      cool_q   <= '0;
      beep_q   <= cdt_pkg::RESET_BEEP_LEFT;
      preset_q <= '0;
      count_q  <= '0;
      run_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s0_v_q <= in_valid_i;
      end
      if (s1_rdy) begin
        s1_v_q <= s0_v_q;
      end
      if (adv) begin
        tick_q   <= tick_d;
        cool_q   <= cool_d;
        beep_q   <= beep_d;
        preset_q <= preset_d;
        count_q  <= count_d;
        run_q    <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_q <= in_i;
    end
    if (adv) begin
      s1_q <= res_d;
    end
  end

  assign tick_inc = tick_q + 16'd1;
  assign sec      = tick_inc >= ms_q;
  assign up_sum   = {1'b0, count_q} + 14'(cdt_pkg::step_for(count_q));
  assign count_m1 = count_q - 13'd1;
  assign deb_x1   = {2'b00, deb_q};
  assign deb_x2   = {1'b0, deb_q, 1'b0};

  always_comb begin
    tick_d   = tick_q;
    cool_d   = cool_q;
    beep_d   = beep_q;
    preset_d = preset_q;
    count_d  = count_q;
    run_d    = run_q;
    expired  = 1'b0;
    report   = 1'b0;
    ignored  = 1'b0;
    unique case (s0_q.mode)
      cdt_pkg::MODE_TICK: begin
        tick_d = sec ? 16'd0 : tick_inc;
        if (sec && run_q) begin
          if (count_q != '0) begin
            count_d = count_m1;
            report  = 1'b1;
          end
          if (count_d == '0) begin
            run_d   = 1'b0;
            expired = 1'b1;
            beep_d  = s0_q.long_end_beep ? long_q : short_q;
          end else if (count_d <= cdt_pkg::WARN_SECONDS && s0_q.warn_enable) begin
            beep_d = short_q;
          end
        end
        if (cool_q != '0) begin
          cool_d = cool_q - 16'd1;
        end
        if (beep_d != '0) begin
          beep_d = beep_d - 16'd1;
        end
      end
      cdt_pkg::MODE_PLAY, cdt_pkg::MODE_STOP, cdt_pkg::MODE_TURN,
      cdt_pkg::MODE_PRESS: begin
        if (cool_q != '0) begin
          ignored = 1'b1;
        end else begin
          cool_d = deb_x1;
          if (s0_q.mode == cdt_pkg::MODE_PLAY) begin
            cool_d = deb_x2;
            beep_d = short_q;
            if (!run_q && count_q != '0) begin
              run_d  = 1'b1;
              tick_d = '0;
            end else begin
              run_d = 1'b0;
            end
          end else if (s0_q.mode == cdt_pkg::MODE_STOP) begin
            cool_d  = deb_x2;
            beep_d  = short_q;
            count_d = preset_q;
            run_d   = 1'b0;
          end else if (s0_q.mode == cdt_pkg::MODE_TURN && !run_q) begin
            if (s0_q.turn_up) begin
              count_d = (up_sum > {1'b0, cdt_pkg::MAX_SECONDS}) ? cdt_pkg::MAX_SECONDS
                                                               : up_sum[cdt_pkg::CountW-1:0];
            end else if (count_q <= cdt_pkg::WARN_SECONDS) begin
              count_d = '0;
            end else begin
              count_d = count_q - 13'(cdt_pkg::step_for(count_m1));
            end
            preset_d = count_d;
            report   = 1'b1;
          end else if (s0_q.mode == cdt_pkg::MODE_PRESS && !run_q) begin
            cool_d   = deb_x2;
            beep_d   = short_q;
            preset_d = '0;
            count_d  = '0;
          end
        end
      end
      default: begin
      end
    endcase
    res_d.seconds_left = count_d;
    res_d.beeper_on    = beep_d != '0;
    res_d.is_armed     = run_d;
    res_d.expired      = expired;
    res_d.report_time  = report;
    res_d.ignored      = ignored;
  end

endmodule

// File: rtl/core/cdt_digits.sv
// Two registered stages that split the count into mm:ss decimal digits.
// Depends on cdt_pkg.
module cdt_digits (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_ready_o,
  input  cdt_pkg::res_t  res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cdt_pkg::disp_t out_o
);

  logic           a_v_q;
  cdt_pkg::res_t  a_res_q;
  logic [6:0]     a_mins_q;
  logic [5:0]     a_secs_q;
  logic           b_v_q;
  cdt_pkg::disp_t b_q;

  logic           a_rdy;
  logic [27:0]    mins_prod;
  logic [6:0]     mins;
  logic [12:0]    secs_full;
  logic [14:0]    mt_prod;
  logic [13:0]    st_prod;
  logic [3:0]     mt;
  logic [2:0]     st;
  logic [6:0]     mo_full;
  logic [5:0]     so_full;
  cdt_pkg::disp_t b_d;

  assign a_rdy       = !b_v_q || out_ready_i;
  assign res_ready_o = !a_v_q || a_rdy;
  assign out_valid_o = b_v_q;
  assign out_o       = b_q;

  assign mins_prod = 28'(res_i.seconds_left) * 28'(cdt_pkg::DIV60_MUL);
  assign mins      = 7'(mins_prod >> cdt_pkg::DIV60_SHIFT);
  assign secs_full = res_i.seconds_left - 13'(mins) * 13'd60;

  assign mt_prod = 15'(a_mins_q) * 15'(cdt_pkg::DIV10_MUL);
  assign st_prod = 14'(a_secs_q) * 14'(cdt_pkg::DIV10_MUL);
  assign mt      = 4'(mt_prod >> cdt_pkg::DIV10_SHIFT);
  assign st      = 3'(st_prod >> cdt_pkg::DIV10_SHIFT);
  assign mo_full = a_mins_q - 7'(mt) * 7'd10;
  assign so_full = a_secs_q - 6'(st) * 6'd10;

  always_comb begin
    b_d.res          = a_res_q;
    b_d.minutes_tens = mt;
    b_d.minutes_ones = mo_full[3:0];
    b_d.seconds_tens = st;
    b_d.seconds_ones = so_full[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (res_ready_o) begin
        a_v_q <= res_valid_i;
      end
      if (a_rdy) begin
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      a_res_q  <= res_i;
      a_mins_q <= mins;
      a_secs_q <= secs_full[5:0];
    end
    if (a_v_q && a_rdy) begin
      b_q <= b_d;
    end
  end

endmodule

// File: rtl/core/countdown_timer_controller_top.sv
// Top level of the countdown timer controller: channel interfaces, state
// update core and digit split. Depends on cdt_pkg, cdt_if, cdt_core, cdt_digits.
//
// The block takes one event transaction per clock cycle while the result
// channel does not stall it, and returns exactly one result transaction per
// event, in order. A result passes through the input register, the state
// update register and the two registers of the digit split, in that order,
// before it is offered on the output. Back-pressure on the result channel
// stalls the pipeline stage by stage without losing throughput.
// Configuration writes take effect on the next edge and must be made while
// no event is in flight.
module countdown_timer_controller_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cdt_pkg::CfgW-1:0]    cfg_data_i,
  cdt_in_if.sink                      in_i,
  cdt_out_if.source                   out_o
);

  cdt_pkg::item_t in_item;
  logic           res_valid;
  logic           res_ready;
  cdt_pkg::res_t  res;
  cdt_pkg::disp_t disp;

  assign in_item.mode          = in_i.mode;
  assign in_item.turn_up       = in_i.turn_up;
  assign in_item.long_end_beep = in_i.long_end_beep;
  assign in_item.warn_enable   = in_i.warn_enable;

  cdt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_i        (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  cdt_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (disp)
  );

  assign out_o.seconds_left = disp.res.seconds_left;
  assign out_o.minutes_tens = disp.minutes_tens;
  assign out_o.minutes_ones = disp.minutes_ones;
  assign out_o.seconds_tens = disp.seconds_tens;
  assign out_o.seconds_ones = disp.seconds_ones;
  assign out_o.beeper_on    = disp.res.beeper_on;
  assign out_o.is_armed     = disp.res.is_armed;
  assign out_o.expired      = disp.res.expired;
  assign out_o.report_time  = disp.res.report_time;
  assign out_o.ignored      = disp.res.ignored;

endmodule

// File: rtl/core/cdt_checker.sv
// Port-level checks for the countdown timer controller, bound to the top
// level. Depends on cdt_pkg and countdown_timer_controller_top.
module cdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [12:0] seconds_left_i,
  input logic [3:0]  minutes_tens_i,
  input logic [2:0]  seconds_tens_i,
  input logic        is_armed_i,
  input logic        expired_i,
  input logic        report_time_i,
  input logic        ignored_i
);

  // A stalled result keeps its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(seconds_left_i))
    else $error("stalled result transaction changed");

  // Expiry leaves the timer disarmed at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && expired_i |-> !is_armed_i && seconds_left_i == 13'd0)
    else $error("expiry with nonzero count or armed timer");

  // A dropped button event changes nothing that is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ignored_i |-> !report_time_i && !expired_i)
    else $error("ignored event reported a change");

  // The count stays within range and its tens digits stay decimal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seconds_left_i <= cdt_pkg::MAX_SECONDS && seconds_tens_i <= 3'd5
                    && minutes_tens_i <= 4'd9)
    else $error("count or digits out of range");

endmodule

bind countdown_timer_controller_top cdt_checker u_cdt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .seconds_left_i (out_o.seconds_left),
  .minutes_tens_i (out_o.minutes_tens),
  .seconds_tens_i (out_o.seconds_tens),
  .is_armed_i     (out_o.is_armed),
  .expired_i      (out_o.expired),
  .report_time_i  (out_o.report_time),
  .ignored_i      (out_o.ignored)
);

// File: verif/testbench.sv
// Self-checking testbench for countdown_timer_controller_top: a directed table, a climb to
// saturation and back down, then random countdown runs and button noise over several register
// settings, checked against an in-bench timer predictor. Depends on cdt_pkg, cdt_if and the RTL.
module testbench;
  import cdt_pkg::*;

  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID   = 3'd6;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int DIRECTED_ROWS   = 21;
  localparam int FIRST_TUNED_ROW = 4;
  localparam int HOLD_CYCLES     = 64;
  localparam int DRAIN_LIMIT     = 5000;

  typedef struct packed {
    item_t ev;
    logic  typed;
  } dir_row_t;

  typedef struct {
    logic [15:0]       ticks;
    logic [15:0]       cooldown;
    logic [15:0]       beep;
    logic [CountW-1:0] preset;
    logic [CountW-1:0] count;
    logic              armed;
  } timer_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  cdt_in_if  in_ch ();
  cdt_out_if out_ch ();

  countdown_timer_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  timer_state_t st;
  logic [15:0] ms_per_sec;
  logic [DebW-1:0] debounce;
  logic [15:0] brief_tone;
  logic [15:0] full_tone;

  disp_t pending_q[$];
  int unsigned sent_events = 0;
  int unsigned checked_results = 0;
  int unsigned errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // Rows with typed set carry the display right after reset: count zero, start-up beep on.
  dir_row_t directed [DIRECTED_ROWS] = '{
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b0}, 1'b1},
    '{'{MODE_UNUSED_FIRST, 1'b1, 1'b0, 1'b0}, 1'b1},
    '{'{MODE_UNUSED_MID,   1'b1, 1'b1, 1'b1}, 1'b1},
    '{'{MODE_UNUSED_LAST,  1'b0, 1'b1, 1'b0}, 1'b1},
    '{'{MODE_TURN,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TURN,         1'b1, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TURN,         1'b1, 1'b1, 1'b0}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_PLAY,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TURN,         1'b1, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_PRESS,        1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b0}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b1}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b1, 1'b1}, 1'b0},
    '{'{MODE_STOP,         1'b0, 1'b0, 1'b0}, 1'b0},
    '{'{MODE_TICK,         1'b1, 1'b0, 1'b0}, 1'b0},
    '{'{MODE_TICK,         1'b0, 1'b0, 1'b0}, 1'b0},
    '{'{MODE_PRESS,        1'b1, 1'b1, 1'b1}, 1'b0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned encoder_step(input logic [CountW-1:0] v);
    if (v < 30) begin
      return 5;
    end else if (v < 120) begin
      return 10;
    end else if (v < 300) begin
      return 30;
    end
    return 60;
  endfunction

  function automatic disp_t readout(input logic [CountW-1:0] cnt, input logic buzz,
                                    input logic armed, input logic expd, input logic rep,
                                    input logic ign);
    disp_t d;
    int unsigned mins;
    int unsigned secs;
    mins = cnt / 60;
    secs = cnt % 60;
    d.res.seconds_left = cnt;
    d.res.beeper_on = buzz;
    d.res.is_armed = armed;
    d.res.expired = expd;
    d.res.report_time = rep;
    d.res.ignored = ign;
    d.minutes_tens = 4'(mins / 10);
    d.minutes_ones = 4'(mins % 10);
    d.seconds_tens = 3'(secs / 10);
    d.seconds_ones = 4'(secs % 10);
    return d;
  endfunction

  // Advances the predicted timer by one event and returns the display it should show.
  function automatic disp_t advance_timer(input item_t ev);
    logic expd;
    logic rep;
    logic ign;
    int unsigned sum;
    expd = 1'b0;
    rep = 1'b0;
    ign = 1'b0;
    if (ev.mode == MODE_TICK) begin
      st.ticks = st.ticks + 16'd1;
      if (st.ticks >= ms_per_sec) begin
        st.ticks = '0;
        if (st.armed) begin
          if (st.count != 0) begin
            st.count = st.count - 13'd1;
            rep = 1'b1;
          end
          if (st.count == 0) begin
            st.armed = 1'b0;
            expd = 1'b1;
            st.beep = ev.long_end_beep ? full_tone : brief_tone;
          end else if (st.count <= WARN_SECONDS && ev.warn_enable) begin
            st.beep = brief_tone;
          end
        end
      end
      if (st.cooldown != 0) st.cooldown = st.cooldown - 16'd1;
      if (st.beep != 0) st.beep = st.beep - 16'd1;
    end else if (ev.mode <= MODE_PRESS) begin
      if (st.cooldown != 0) begin
        ign = 1'b1;
      end else begin
        st.cooldown = 16'(debounce);
        case (ev.mode)
          MODE_PLAY: begin
            st.cooldown = st.cooldown + 16'(debounce);
            st.beep = brief_tone;
            if (!st.armed && st.count != 0) begin
              st.armed = 1'b1;
              st.ticks = '0;
            end else if (st.armed) begin
              st.armed = 1'b0;
            end
          end
          MODE_STOP: begin
            st.cooldown = st.cooldown + 16'(debounce);
            st.beep = brief_tone;
            st.count = st.preset;
            st.armed = 1'b0;
          end
          MODE_TURN: begin
            if (!st.armed) begin
              if (ev.turn_up) begin
                sum = st.count + encoder_step(st.count);
                if (sum > MAX_SECONDS) sum = MAX_SECONDS;
                st.count = 13'(sum);
              end else if (st.count <= 5) begin
                st.count = '0;
              end else begin
                st.count = 13'(st.count - encoder_step(st.count - 13'd1));
              end
              st.preset = st.count;
              rep = 1'b1;
            end
          end
          MODE_PRESS: begin
            if (!st.armed) begin
              st.cooldown = st.cooldown + 16'(debounce);
              st.beep = brief_tone;
              st.preset = '0;
              st.count = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
    return readout(st.count, st.beep != 0, st.armed, expd, rep, ign);
  endfunction

  function automatic item_t make_event(input mode_e m, input logic up);
    item_t ev;
    ev.mode = m;
    ev.turn_up = up;
    ev.long_end_beep = 1'($urandom_range(0, 1));
    ev.warn_enable = $urandom_range(0, 99) < 75;
    return ev;
  endfunction

  function automatic item_t random_event();
    item_t ev;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    ev = make_event(MODE_TICK, $urandom_range(0, 99) < 65);
    if (pick >= 96) begin
      ev.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    end else if (pick >= 92) begin
      ev.mode = MODE_PRESS;
    end else if (pick >= 88) begin
      ev.mode = MODE_STOP;
    end else if (pick >= 80) begin
      ev.mode = MODE_PLAY;
    end else if (pick >= 62) begin
      ev.mode = MODE_TURN;
    end
    return ev;
  endfunction

  task automatic log_error(input string msg);
    if (errors < 100) $display("ERROR at %0t, result %0d: %s", $time, checked_results, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) log_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic push_event(input item_t ev, input logic typed);
    disp_t want;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= ev.mode;
    in_ch.turn_up <= ev.turn_up;
    in_ch.long_end_beep <= ev.long_end_beep;
    in_ch.warn_enable <= ev.warn_enable;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    want = advance_timer(ev);
    if (typed) want = readout('0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    pending_q.push_back(want);
    sent_events++;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_q.size() != 0) begin
      log_error($sformatf("%0d results never arrived", pending_q.size()));
    end
  endtask

  task automatic apply_config(input logic [15:0] ms, input logic [DebW-1:0] deb,
                              input logic [15:0] sb, input logic [15:0] lb);
    logic [CfgIdxW-1:0] idx [4];
    logic [CfgW-1:0] val [4];
    int i;
    idx[0] = REG_MS_PER_SECOND;
    idx[1] = REG_DEBOUNCE_MS;
    idx[2] = REG_SHORT_BEEP_MS;
    idx[3] = REG_LONG_BEEP_MS;
    val[0] = ms;
    val[1] = 16'(deb);
    val[2] = sb;
    val[3] = lb;
    for (i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    ms_per_sec = ms;
    debounce = deb;
    brief_tone = sb;
    full_tone = lb;
  endtask

  // Mostly well-formed runs: set a preset, start, let it count down to expiry with
  // occasional stray buttons; the rest is plain random button noise.
  task automatic random_phase(input int unsigned target);
    int unsigned stop_at;
    int guard;
    int n;
    stop_at = sent_events + target;
    while (sent_events < stop_at) begin
      if ($urandom_range(0, 9) < 6) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          push_event(make_event(MODE_TURN, $urandom_range(0, 99) < 80), 1'b0);
          guard = 0;
          while (st.cooldown != 0 && guard < 40) begin
            push_event(make_event(MODE_TICK, 1'($urandom_range(0, 1))), 1'b0);
            guard++;
          end
        end
        push_event(make_event(MODE_PLAY, 1'($urandom_range(0, 1))), 1'b0);
        guard = 0;
        while (st.armed && guard < 300) begin
          if ($urandom_range(0, 9) == 0) begin
            push_event(random_event(), 1'b0);
          end else begin
            push_event(make_event(MODE_TICK, 1'($urandom_range(0, 1))), 1'b0);
          end
          guard++;
        end
      end else begin
        repeat (10) push_event(random_event(), 1'b0);
      end
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    disp_t got;
    disp_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.res.seconds_left = out_ch.seconds_left;
      got.res.beeper_on = out_ch.beeper_on;
      got.res.is_armed = out_ch.is_armed;
      got.res.expired = out_ch.expired;
      got.res.report_time = out_ch.report_time;
      got.res.ignored = out_ch.ignored;
      got.minutes_tens = out_ch.minutes_tens;
      got.minutes_ones = out_ch.minutes_ones;
      got.seconds_tens = out_ch.seconds_tens;
      got.seconds_ones = out_ch.seconds_ones;
      if (pending_q.size() == 0) begin
        log_error("result transaction with nothing expected");
      end else begin
        want = pending_q.pop_front();
        check_field("seconds_left", got.res.seconds_left, want.res.seconds_left);
        check_field("minutes_tens", got.minutes_tens, want.minutes_tens);
        check_field("minutes_ones", got.minutes_ones, want.minutes_ones);
        check_field("seconds_tens", got.seconds_tens, want.seconds_tens);
        check_field("seconds_ones", got.seconds_ones, want.seconds_ones);
        check_field("beeper_on", got.res.beeper_on, want.res.beeper_on);
        check_field("is_armed", got.res.is_armed, want.res.is_armed);
        check_field("expired", got.res.expired, want.res.expired);
        check_field("report_time", got.res.report_time, want.res.report_time);
        check_field("ignored", got.res.ignored, want.res.ignored);
      end
      checked_results++;
    end
  end

  initial begin : stimulus
    int i;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_TICK;
    in_ch.turn_up <= 1'b0;
    in_ch.long_end_beep <= 1'b0;
    in_ch.warn_enable <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_MS_PER_SECOND;
    cfg_data_i <= '0;
    ms_per_sec = RESET_MS_PER_SECOND;
    debounce = RESET_DEBOUNCE_MS;
    brief_tone = RESET_SHORT_BEEP_MS;
    full_tone = RESET_LONG_BEEP_MS;
    st.ticks = '0;
    st.cooldown = '0;
    st.beep = RESET_BEEP_LEFT;
    st.preset = '0;
    st.count = '0;
    st.armed = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == FIRST_TUNED_ROW) begin
        wait_idle();
        apply_config(16'd1, 14'd1, 16'd2, 16'd3);
      end
      push_event(directed[i].ev, directed[i].typed);
    end

    // Climb to the saturation limit, run briefly, then step all the way down.
    wait_idle();
    apply_config(16'd1, 14'd0, 16'd3, 16'd7);
    repeat (128) begin
      if ($urandom_range(0, 3) == 0) push_event(make_event(MODE_TICK, 1'b1), 1'b0);
      push_event(make_event(MODE_TURN, 1'b1), 1'b0);
    end
    push_event(make_event(MODE_PLAY, 1'b0), 1'b0);
    repeat (30) push_event(make_event(MODE_TICK, 1'b0), 1'b0);
    push_event(make_event(MODE_PLAY, 1'b0), 1'b0);
    repeat (128) begin
      if ($urandom_range(0, 3) == 0) push_event(make_event(MODE_TICK, 1'b0), 1'b0);
      push_event(make_event(MODE_TURN, 1'b0), 1'b0);
    end

    wait_idle();
    apply_config(16'd2, 14'd1, 16'd2, 16'd5);
    hold_req = 1'b1;
    random_phase(350);

    wait_idle();
    apply_config(16'd0, 14'd0, 16'd0, 16'd0);
    random_phase(250);

    wait_idle();
    apply_config(16'd3, 14'd2, 16'd1, 16'hFFFF);
    random_phase(350);

    wait_idle();
    idle_on = 1'b0;
    apply_config(16'd1, 14'd0, 16'd5, 16'd9);
    random_phase(300);

    wait_idle();
    apply_config(16'hFFFF, 14'h3FFF, 16'hFFFF, 16'hFFFF);
    random_phase(100);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cdt_pkg.sv
rtl/core/cdt_if.sv
rtl/core/cdt_core.sv
rtl/core/cdt_digits.sv
rtl/core/countdown_timer_controller_top.sv
rtl/core/cdt_checker.sv
verif/testbench.sv
